/* rtl/hkmp_pkg.sv */
// ----------------------------------------------------------------------------
// hkmp_pkg
// shared types and constants of the kernel map predictor
// ----------------------------------------------------------------------------
`default_nettype none
package hkmp_pkg;
   localparam logic [1:0] OP_TABLE  = 2'd0;
   localparam logic [1:0] OP_WEIGHT = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;

   localparam logic [1:0] REG_ORDER   = 2'd0;
   localparam logic [1:0] REG_MIN_EXP = 2'd1;
   localparam logic [1:0] REG_MAX_EXP = 2'd2;
   localparam logic [1:0] REG_BIAS    = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PLAIN, ST_RDA, ST_RDB, ST_INTERP, ST_MUL, ST_ACC,
      ST_BIAS_RD, ST_BIAS_MUL, ST_BIAS_ACC, ST_OUT
   } state_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63])
         sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else
         sat_add = s[63:0];
   endfunction

   function automatic logic [31:0] to_q16(input logic [63:0] bits);
      logic [10:0] eb;
      logic [52:0] mant;
      logic [11:0] rs;
      eb = bits[62:52];
      mant = {1'b1, bits[51:0]};
      rs = 12'd1059 - {1'b0, eb};
      if (bits[63])
         to_q16 = 32'd0;
      else if (eb == 11'h7ff)
         to_q16 = (bits[51:0] != 52'd0) ? 32'd0 : 32'h7fffffff;
      else if (eb == 11'd0)
         to_q16 = 32'd0;
      else if (eb >= 11'd1038)
         to_q16 = 32'h7fffffff;
      else if (eb < 11'd996)
         to_q16 = 32'd0;
      else
         to_q16 = 32'(mant >> rs[5:0]);
   endfunction
endpackage
`default_nettype wire

/* rtl/hkmp_store.sv */
// ----------------------------------------------------------------------------
// hkmp_store
// single port synchronous memory with a registered read
// ----------------------------------------------------------------------------
`default_nettype none
module hkmp_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] addr,
   input  wire logic [31:0]   wr_data,
   output logic      [31:0]   rd_data
);
   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

/* rtl/homogeneous_kernel_map_predict.sv */
// ----------------------------------------------------------------------------
// homogeneous_kernel_map_predict
// linear scoring over a homogeneous kernel feature map
// ----------------------------------------------------------------------------
// One word at a time. A map feature inside the window walks its 2*order+1
// coefficients, each with three memory reads and a multiply-accumulate over
// the single table port and weight port (RDA, RDB, INTERP, MUL, ACC); a plain
// feature goes through PLAIN and ACC, a feature that adds nothing returns to
// idle, and the last feature adds the bias steps and a result hand-off.
`default_nettype none
module homogeneous_kernel_map_predict
   import hkmp_pkg::*;
#(
   parameter int MAX_ORDER    = 3,
   parameter int MAX_FEATURES = 1024,
   parameter int SUBDIV       = 8,
   parameter int EXP_SPAN     = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // index[12:0], value[76:13], pad
   input  wire logic [1:0]  req_tuser,   // op
   input  wire logic        req_tlast,   // last_feature
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // score[63:0], feature_count[74:64], pad
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int ROW_MAX = 2 * MAX_ORDER + 1;
   localparam int TDEPTH  = EXP_SPAN * SUBDIV * ROW_MAX;
   localparam int WDEPTH  = MAX_FEATURES * ROW_MAX + 1;
   localparam int TAW     = $clog2(TDEPTH);
   localparam int WAW     = $clog2(WDEPTH);
   localparam int SUBW    = $clog2(SUBDIV);
   localparam int FPW     = $clog2(MAX_FEATURES + 1);
   localparam int LW      = $clog2(ROW_MAX + 1);

   logic [1:0]         order_ff;
   logic signed [10:0] min_exp_ff, max_exp_ff;
   logic signed [31:0] bias_ff;
   state_type          state_ff, state_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [FPW-1:0]     pos_ff, pos_in;
   logic [63:0]        val_ff, val_in;
   logic               last_ff, last_in;
   logic [LW-1:0]      l_ff, l_in;
   logic [LW-1:0]      n1_ff, n1_in;
   logic [TAW+1:0]     row_ff, row_in;
   logic [15:0]        t_ff, t_in;
   logic [WAW+1:0]     base_ff, base_in;
   logic signed [31:0] a_ff, a_in, c_ff, c_in, op_ff, op_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0]        rsp_score_ff, rsp_score_in;
   logic [FPW-1:0]     rsp_cnt_ff, rsp_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [1:0]         ord;
   logic [12:0]        idx;
   logic               t_we, w_we;
   logic [TAW-1:0]     t_addr;
   logic [WAW-1:0]     w_addr;
   logic [TAW+1:0]     t_full;
   logic [WAW+1:0]     w_full;
   logic               t_ok, w_ok;
   logic [31:0]        t_rd, w_rd;
   logic               acc_now;
   logic signed [12:0] e, top, topb;
   logic [SUBW+52:0]   p;
   logic               in_win;
   logic signed [48:0] diff_t;

   assign idx = req_tdata[12:0];
   assign ord = (32'(order_ff) > MAX_ORDER) ? 2'(MAX_ORDER) : order_ff;
   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign acc_now = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'd0, 11'(rsp_cnt_ff), rsp_score_ff};

   hkmp_store #(.DEPTH(TDEPTH), .AW(TAW)) u_table (
      .clock(clock), .wr_en(t_we), .addr(t_addr), .wr_data(req_tdata[44:13]),
      .rd_data(t_rd));
   hkmp_store #(.DEPTH(WDEPTH), .AW(WAW)) u_weight (
      .clock(clock), .wr_en(w_we), .addr(w_addr), .wr_data(req_tdata[44:13]),
      .rd_data(w_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= '0; min_exp_ff <= -11'sd20; max_exp_ff <= 11'sd8;
         bias_ff <= 32'sd65536;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ORDER:   order_ff <= csr_data[1:0];
            REG_MIN_EXP: min_exp_ff <= csr_data[10:0];
            REG_MAX_EXP: max_exp_ff <= csr_data[10:0];
            REG_BIAS:    bias_ff <= csr_data;
            default:     ;
         endcase
      end
   end

   // window and row for an arriving sample
   always_comb begin
      e = 13'(signed'({2'b0, req_tdata[75:65]})) - 13'sd1023;
      topb = 13'(min_exp_ff) + 13'(EXP_SPAN - 1);
      top = (13'(max_exp_ff) < topb) ? 13'(max_exp_ff) : topb;
      p = (SUBW+53)'(req_tdata[64:13]) * (SUBW+53)'(SUBDIV);
      in_win = !req_tdata[76] && (req_tdata[75:65] != 11'd0) &&
               (e > 13'(min_exp_ff)) && (e < top);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (acc_now && req_tuser == OP_SAMPLE) begin
               if (32'(pos_ff) >= MAX_FEATURES)
                  state_in = req_tlast ? ST_BIAS_RD : ST_IDLE;
               else if (ord == 2'd0)
                  state_in = ST_PLAIN;
               else if (in_win)
                  state_in = ST_RDA;
               else
                  state_in = req_tlast ? ST_BIAS_RD : ST_IDLE;
            end
         ST_PLAIN:    state_in = ST_ACC;
         ST_RDA:      state_in = ST_RDB;
         ST_RDB:      state_in = ST_INTERP;
         ST_INTERP:   state_in = ST_MUL;
         ST_MUL:      state_in = ST_ACC;
         ST_ACC:
            if (l_ff + 1'b1 < n1_ff) state_in = ST_RDA;
            else state_in = last_ff ? ST_BIAS_RD : ST_IDLE;
         ST_BIAS_RD:  state_in = ST_BIAS_MUL;
         ST_BIAS_MUL: state_in = ST_BIAS_ACC;
         ST_BIAS_ACC: state_in = ST_OUT;
         ST_OUT:      state_in = (!rsp_valid_ff || rsp_tready) ? ST_IDLE : ST_OUT;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      acc_in = acc_ff; pos_in = pos_ff; val_in = val_ff; last_in = last_ff;
      l_in = l_ff; n1_in = n1_ff; row_in = row_ff; t_in = t_ff; base_in = base_ff;
      a_in = a_ff; c_in = c_ff; op_in = op_ff; prod_in = prod_ff;
      rsp_score_in = rsp_score_ff; rsp_cnt_in = rsp_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      t_we = 1'b0; w_we = 1'b0;
      t_full = '0; w_full = '0;
      diff_t = '0;
      case (state_ff)
         ST_IDLE: begin
            if (acc_now) begin
               if (req_tuser == OP_TABLE) begin
                  t_full = (TAW+2)'(idx);
                  t_we = 32'(idx) < TDEPTH;
               end else if (req_tuser == OP_WEIGHT) begin
                  w_full = (WAW+2)'(idx);
                  w_we = 32'(idx) < WDEPTH;
               end else if (req_tuser == OP_SAMPLE) begin
                  last_in = req_tlast;
                  val_in = req_tdata[76:13];
                  n1_in = LW'({ord, 1'b1});
                  l_in = '0;
                  base_in = (WAW+2)'(pos_ff) * (WAW+2)'({ord, 1'b1});
                  row_in = (TAW+2)'((e - 13'(min_exp_ff)) * 13'(SUBDIV)) +
                           (TAW+2)'(p[SUBW+52:52]);
                  t_in = p[51:36];
                  w_full = (WAW+2)'(pos_ff) * (WAW+2)'({ord, 1'b1});
                  if (32'(pos_ff) < MAX_FEATURES) pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_PLAIN: begin
            c_in = signed'(to_q16(val_ff));
            op_in = signed'(w_rd);
            n1_in = LW'(1);
         end
         ST_RDA: begin
            t_full = (TAW+2)'(row_ff * (TAW+2)'(n1_ff)) + (TAW+2)'(l_ff);
            w_full = base_ff + (WAW+2)'(l_ff);
         end
         ST_RDB: begin
            a_in = signed'(t_rd);
            op_in = signed'(w_rd);
            t_full = (TAW+2)'((row_ff + 1'b1) * (TAW+2)'(n1_ff)) + (TAW+2)'(l_ff);
         end
         ST_INTERP: begin
            diff_t = 49'(33'(signed'(t_rd)) - 33'(a_ff)) *
                     49'(signed'({17'd0, t_ff}));
            c_in = 32'(33'(a_ff) + 33'(diff_t >>> 16));
         end
         ST_MUL: prod_in = 64'(c_ff) * 64'(op_ff);
         ST_ACC: begin
            acc_in = sat_add(acc_ff, (n1_ff == LW'(1) && l_ff == '0 && ord == 2'd0)
                                     ? 64'(c_ff) * 64'(op_ff) : prod_ff);
            l_in = l_ff + 1'b1;
         end
         ST_BIAS_RD: w_full = (WAW+2)'(pos_ff) * (WAW+2)'({ord, 1'b1});
         ST_BIAS_MUL: prod_in = 64'(bias_ff) * 64'(signed'(w_rd));
         ST_BIAS_ACC:
            if (bias_ff != 32'sd0) acc_in = sat_add(acc_ff, prod_ff);
         ST_OUT:
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_score_in = acc_ff; rsp_cnt_in = pos_ff; rsp_valid_in = 1'b1;
               acc_in = '0; pos_in = '0;
            end
         default: ;
      endcase
      t_ok = 32'(t_full) < TDEPTH;
      w_ok = 32'(w_full) < WDEPTH;
      t_addr = t_ok ? t_full[TAW-1:0] : '0;
      w_addr = w_ok ? w_full[WAW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; acc_ff <= '0; pos_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; acc_ff <= acc_in; pos_ff <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in; last_ff <= last_in; l_ff <= l_in; n1_ff <= n1_in;
      row_ff <= row_in; t_ff <= t_in; base_ff <= base_in; a_ff <= a_in;
      c_ff <= c_in; op_ff <= op_in; prod_ff <= prod_in;
      rsp_score_ff <= rsp_score_in; rsp_cnt_ff <= rsp_cnt_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) <= MAX_FEATURES) else $error("feature count overflow");
   a_out_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && rsp_tready |=> pos_ff == '0)
      else $error("position not cleared");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready outside idle");
endmodule
`default_nettype wire
